// ===== rtl/core/pulse_width_capture_timeout_core_assert.svh =====
// Assertion macros used by the checker file of the pulse width capture block.
`ifndef PULSE_WIDTH_CAPTURE_TIMEOUT_CORE_ASSERT_SVH
`define PULSE_WIDTH_CAPTURE_TIMEOUT_CORE_ASSERT_SVH

// Checked at every rising edge outside of reset.
`define PWCT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pwct assertion failed");

// Checked at every rising edge, during reset as well.
`define PWCT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pwct assertion failed");

`endif

// ===== rtl/core/pwct_pkg.sv =====
// ----------------------------------------------------------------------------
// pwct_pkg
// Types and constants of the pulse width capture and timeout block.
// ----------------------------------------------------------------------------
package pwct_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned ChAddrW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgActiveChannels   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTimerPeriod      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSupervisorTimeout = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeoutCode      = 3'd3;

  localparam logic [3:0]  ActiveChannelsRst    = 4'd1;
  localparam logic [15:0] TimerPeriodRst       = 16'hFFFF;
  localparam logic [31:0] SupervisorTimeoutRst = 32'd100000;
  localparam logic [31:0] TimeoutCodeRst       = 32'd0;

  // Event kinds.
  localparam logic FuncEdge     = 1'b0;
  localparam logic FuncOverflow = 1'b1;

  typedef struct packed {
    logic [3:0]  active_channels;
    logic [15:0] timer_period;
    logic [31:0] supervisor_timeout;
    logic [31:0] timeout_code;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [2:0]  channel;
    logic [15:0] count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  channel_out;
    logic [31:0] pulse_width;
    logic [31:0] completed_count;
    logic        pulse_done;
    logic        timed_out;
    logic        rejected;
  } out_item_t;

  typedef struct packed {
    logic        awaiting_fall;
    logic [15:0] rise_time;
    logic [15:0] fall_time;
    logic [31:0] width_value;
    logic [31:0] done_count;
    logic [31:0] elapsed_time;
  } chan_state_t;

  // A channel that was never written holds this; its width equals the reset timeout code.
  localparam chan_state_t StateRst = '{
    awaiting_fall: 1'b0,
    rise_time:     16'd0,
    fall_time:     16'd0,
    width_value:   TimeoutCodeRst,
    done_count:    32'd0,
    elapsed_time:  32'd0
  };

  typedef struct packed {
    logic               rd_en;
    logic [ChAddrW-1:0] rd_addr;
    logic               wr_en;
    logic [ChAddrW-1:0] wr_addr;
  } ram_req_t;

  typedef struct packed {
    logic [31:0] pulse_width;
    logic [31:0] completed_count;
    logic        pulse_done;
    logic        timed_out;
  } upd_res_t;

endpackage

// ===== rtl/core/pwct_state_ram.sv =====
// ----------------------------------------------------------------------------
// pwct_state_ram
// Per-channel state memory with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module pwct_state_ram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwct_pkg::ram_req_t    req_i,
  input  pwct_pkg::chan_state_t wr_data_i,
  output pwct_pkg::chan_state_t rd_data_o
);

  pwct_pkg::chan_state_t mem [pwct_pkg::NumChannels];
  pwct_pkg::chan_state_t rd_data_q;

  logic [pwct_pkg::NumChannels-1:0] ent_valid_q;
  logic                             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        ent_valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= ent_valid_q[req_i.rd_addr];
      end
    end
  end

  // An entry not written since reset reads as the reset state.
  assign rd_data_o = rd_valid_q ? rd_data_q : pwct_pkg::StateRst;

endmodule

// ===== rtl/core/pwct_update.sv =====
// ----------------------------------------------------------------------------
// pwct_update
// Next-state and result logic for one event applied to one channel state.
// ----------------------------------------------------------------------------
module pwct_update (
  input  logic                  func_i,
  input  logic [15:0]           count_i,
  input  pwct_pkg::chan_state_t state_i,
  input  pwct_pkg::cfg_t        cfg_i,
  output pwct_pkg::chan_state_t next_o,
  output pwct_pkg::upd_res_t    res_o
);

  logic [31:0] direct_width;
  logic [31:0] wrap_width;
  logic [32:0] elapsed_sum;
  logic [31:0] elapsed_sat;
  logic        done;
  logic        tmo;

  assign direct_width = 32'(count_i) - 32'(state_i.rise_time);
  // Pulse ran through the auto-reload point of the timer.
  assign wrap_width   = 32'(cfg_i.timer_period) + 32'd1 - 32'(state_i.rise_time)
                        + 32'(count_i);
  assign elapsed_sum  = {1'b0, state_i.elapsed_time} + 33'(count_i);
  assign elapsed_sat  = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];

  always_comb begin
    next_o = state_i;
    done   = 1'b0;
    tmo    = 1'b0;
    case (func_i)
      pwct_pkg::FuncEdge: begin
        if (!state_i.awaiting_fall) begin
          next_o.rise_time     = count_i;
          next_o.elapsed_time  = 32'd0;
          next_o.awaiting_fall = 1'b1;
        end else begin
          next_o.fall_time     = count_i;
          next_o.width_value   = (count_i > state_i.rise_time) ? direct_width : wrap_width;
          next_o.awaiting_fall = 1'b0;
          next_o.done_count    = state_i.done_count + 32'd1;
          done                 = 1'b1;
        end
      end
      pwct_pkg::FuncOverflow: begin
        next_o.elapsed_time = elapsed_sat;
        if (elapsed_sat >= cfg_i.supervisor_timeout) begin
          next_o.awaiting_fall = 1'b0;
          next_o.rise_time     = 16'd0;
          next_o.fall_time     = 16'd0;
          next_o.width_value   = cfg_i.timeout_code;
          next_o.elapsed_time  = 32'd0;
          tmo                  = 1'b1;
        end
      end
      default: begin
        next_o = state_i;
      end
    endcase
  end

  assign res_o.pulse_width     = next_o.width_value;
  assign res_o.completed_count = next_o.done_count;
  assign res_o.pulse_done      = done;
  assign res_o.timed_out       = tmo;

endmodule

// ===== rtl/core/pulse_width_capture_timeout_core.sv =====
// ----------------------------------------------------------------------------
// pulse_width_capture_timeout_core
// Multi-channel pulse width capture with supervisor timeout, channel state
// held in a read-modify-write memory.
//
//   Port group   Handshake                   Payload
//   in           in_valid_i / in_ready_o     in_item_i  (func, channel, count)
//   out          out_valid_o / out_ready_i   out_item_o (channel_out .. rejected)
//   cfg          cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// One beat is accepted per cycle while the output is not stalled; its result is
// registered after the state memory read and again after the update stage.
// Back-to-back beats on the same channel take the written state by forwarding.
// Reset clears the per-entry valid bits at once; there is no clearing pass.
// A stalled output holds the update stage, which in turn holds the input.
// ----------------------------------------------------------------------------
module pulse_width_capture_timeout_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pwct_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pwct_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [pwct_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pwct_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  pwct_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_channels    <= pwct_pkg::ActiveChannelsRst;
      cfg_q.timer_period       <= pwct_pkg::TimerPeriodRst;
      cfg_q.supervisor_timeout <= pwct_pkg::SupervisorTimeoutRst;
      cfg_q.timeout_code       <= pwct_pkg::TimeoutCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pwct_pkg::CfgActiveChannels:    cfg_q.active_channels    <= cfg_wdata_i[3:0];
        pwct_pkg::CfgTimerPeriod:       cfg_q.timer_period       <= cfg_wdata_i[15:0];
        pwct_pkg::CfgSupervisorTimeout: cfg_q.supervisor_timeout <= cfg_wdata_i;
        pwct_pkg::CfgTimeoutCode:       cfg_q.timeout_code       <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Pipeline control.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic in_acc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Address and range check of the incoming beat.
  logic [3:0]                   ch_ext;
  logic [pwct_pkg::ChAddrW-1:0] in_addr;
  logic                         in_rej;

  assign ch_ext  = {1'b0, in_item_i.channel};
  assign in_addr = ch_ext[pwct_pkg::ChAddrW-1:0];
  assign in_rej  = (ch_ext >= cfg_q.active_channels) ||
                   ({2'b00, in_item_i.channel} >= 5'(pwct_pkg::NumChannels));

  // Update stage registers.
  logic                         s1_func_q;
  logic [2:0]                   s1_ch_q;
  logic [15:0]                  s1_count_q;
  logic                         s1_rej_q;
  logic [pwct_pkg::ChAddrW-1:0] s1_addr_q;
  logic                         fwd_hit_q;
  pwct_pkg::chan_state_t        fwd_data_q;

  pwct_pkg::ram_req_t    ram_req;
  pwct_pkg::chan_state_t ram_rd;
  pwct_pkg::chan_state_t cur_state;
  pwct_pkg::chan_state_t next_state;
  pwct_pkg::upd_res_t    upd_res;
  logic                  fwd_hit_d;

  assign ram_req.rd_en   = in_acc;
  assign ram_req.rd_addr = in_addr;
  assign ram_req.wr_en   = s1_adv && !s1_rej_q;
  assign ram_req.wr_addr = s1_addr_q;

  // The memory read issued with this write still returns the old entry.
  assign fwd_hit_d = ram_req.wr_en && (ram_req.wr_addr == in_addr);

  pwct_state_ram u_state_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .wr_data_i (next_state),
    .rd_data_o (ram_rd)
  );

  assign cur_state = fwd_hit_q ? fwd_data_q : ram_rd;

  pwct_update u_update (
    .func_i  (s1_func_q),
    .count_i (s1_count_q),
    .state_i (cur_state),
    .cfg_i   (cfg_q),
    .next_o  (next_state),
    .res_o   (upd_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (in_acc) begin
        fwd_hit_q <= fwd_hit_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  pwct_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q  <= in_item_i.func;
      s1_ch_q    <= in_item_i.channel;
      s1_count_q <= in_item_i.count;
      s1_rej_q   <= in_rej;
      s1_addr_q  <= in_addr;
      fwd_data_q <= next_state;
    end
    if (s1_adv) begin
      out_item_q.channel_out <= s1_ch_q;
      if (s1_rej_q) begin
        out_item_q.pulse_width     <= 32'd0;
        out_item_q.completed_count <= 32'd0;
        out_item_q.pulse_done      <= 1'b0;
        out_item_q.timed_out       <= 1'b0;
        out_item_q.rejected        <= 1'b1;
      end else begin
        out_item_q.pulse_width     <= upd_res.pulse_width;
        out_item_q.completed_count <= upd_res.completed_count;
        out_item_q.pulse_done      <= upd_res.pulse_done;
        out_item_q.timed_out       <= upd_res.timed_out;
        out_item_q.rejected        <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/pwct_checker.sv =====
// ----------------------------------------------------------------------------
// pwct_checker
// Port-level checks of the pulse width capture block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pulse_width_capture_timeout_core_assert.svh"

module pwct_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pwct_pkg::out_item_t out_item_o
);

  `PWCT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))

  `PWCT_ASSERT_ALWAYS(a_rst_no_out, clk_i, !rst_ni |-> !out_valid_o)

  `PWCT_ASSERT(a_rej_zero, clk_i, rst_ni, out_valid_o && out_item_o.rejected |-> out_item_o.pulse_width == 32'd0 && out_item_o.completed_count == 32'd0 && !out_item_o.pulse_done && !out_item_o.timed_out)

  `PWCT_ASSERT(a_done_xor_tmo, clk_i, rst_ni, out_valid_o |-> !(out_item_o.pulse_done && out_item_o.timed_out))

endmodule

bind pulse_width_capture_timeout_core pwct_checker u_pwct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
